// File: design/dem_tile_bilinear_elevation_macros.svh
`ifndef DEM_TILE_BILINEAR_ELEVATION_MACROS_SVH
`define DEM_TILE_BILINEAR_ELEVATION_MACROS_SVH

// Check a property on every clock edge outside reset.
`define DTBE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a consequence on the same edge.
`define DTBE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: design/dtbe_pkg.sv
package dtbe_pkg;

  localparam int TILE_SIDE  = 1201;
  localparam int IDX_W      = 21;
  localparam int SAMPLE_W   = 16;
  localparam int FRAC_W     = 20;
  localparam int WFRAC_W    = 12;
  localparam int HEIGHT_W   = 20;

  localparam int COORD_W    = $clog2(TILE_SIDE);
  localparam int HALF_SIDE  = (TILE_SIDE + 1) / 2;
  localparam int BANK_DEPTH = HALF_SIDE * HALF_SIDE;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);
  localparam int NUM_BANKS  = 4;
  localparam longint TILE_CELLS = longint'(TILE_SIDE) * longint'(TILE_SIDE);

  localparam int RECIP_SHIFT = IDX_W + COORD_W;
  localparam int RECIP_W     = IDX_W + 1;
  localparam int PROD_W      = RECIP_SHIFT + COORD_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((longint'(1) << RECIP_SHIFT) + longint'(TILE_SIDE) - 1) / longint'(TILE_SIDE));

  localparam int POS_W    = FRAC_W + COORD_W;
  localparam int WEIGHT_W = 2 * WFRAC_W + 1;
  localparam int MAC_W    = SAMPLE_W + WEIGHT_W + 1;

  localparam logic [SAMPLE_W-1:0] VOID_SAMPLE = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [MAC_W-1:0]    ROUND_BIAS  = MAC_W'(1) << (FRAC_W - 1);

  localparam int LATENCY = 8;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e                      mode;
    logic [IDX_W-1:0]           sample_index;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [FRAC_W-1:0]          lat_fraction;
    logic [FRAC_W-1:0]          lon_fraction;
  } item_t;

  typedef struct packed {
    logic signed [HEIGHT_W-1:0] height_q4;
    logic                       void_found;
  } result_t;

  typedef struct packed {
    logic [NUM_BANKS-1:0]              wr_en;
    logic [NUM_BANKS-1:0][BANK_AW-1:0] addr;
    logic [SAMPLE_W-1:0]               wdata;
  } mem_req_t;

  typedef struct packed {
    logic                               valid;
    logic                               row_odd;
    logic                               col_odd;
    logic [NUM_BANKS-1:0][WEIGHT_W-1:0] weight;
  } blend_ctl_t;

  typedef logic [NUM_BANKS-1:0][SAMPLE_W-1:0] bank_data_t;

  function automatic logic [1:0] bank_of(input logic row_odd, input logic col_odd);
    return {row_odd, col_odd};
  endfunction

endpackage

// File: design/dem_tile_bilinear_elevation.sv
// Bilinear elevation lookup in one square tile of signed 16-bit samples. Every
// cycle one beat is taken (busy stays low): a load beat writes one sample, a
// query beat gives one result beat via the address, RAM and blend registers, marked
// by done for a single cycle. The receiver cannot stall, so a result must be
// captured in the cycle it is shown. Loads give no result and an index beyond
// the tile is dropped. The tile sits in four single-port memories banked by row
// and column parity, so the four neighbours of a query are read in one access;
// that one access per beat sets the rate of one beat per cycle. Loads and
// queries travel the same pipeline in order, so a query sees every earlier
// load. A sample must be loaded before any query touches it. A void neighbour
// sets void_found and forces the height to zero.
`include "dem_tile_bilinear_elevation_macros.svh"

module dem_tile_bilinear_elevation (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  dtbe_pkg::item_t    item,
  output logic               done,
  output dtbe_pkg::result_t  result
);

  logic                  accept;
  dtbe_pkg::mem_req_t    mem_req;
  dtbe_pkg::blend_ctl_t  ctl;
  dtbe_pkg::bank_data_t  rdata;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  dtbe_addr u_addr (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .item    (item),
    .mem_req (mem_req),
    .ctl     (ctl)
  );

  for (genvar b = 0; b < dtbe_pkg::NUM_BANKS; b++) begin : g_bank
    dtbe_bank_ram #(
      .DEPTH (dtbe_pkg::BANK_DEPTH),
      .WIDTH (dtbe_pkg::SAMPLE_W)
    ) u_bank (
      .clk   (clk),
      .wr_en (mem_req.wr_en[b]),
      .addr  (mem_req.addr[b]),
      .wdata (mem_req.wdata),
      .rdata (rdata[b])
    );
  end

  dtbe_blend u_blend (
    .clk    (clk),
    .rst    (rst),
    .rdata  (rdata),
    .ctl    (ctl),
    .done   (done),
    .result (result)
  );

  `DTBE_ASSERT_IMP(a_done_latency, done, $past(accept && item.mode == dtbe_pkg::MODE_QUERY, dtbe_pkg::LATENCY), "result beat without query beat")

endmodule

// File: design/dtbe_bank_ram.sv
module dtbe_bank_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: design/dtbe_addr.sv
`include "dem_tile_bilinear_elevation_macros.svh"

module dtbe_addr (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  dtbe_pkg::item_t       item,
  output dtbe_pkg::mem_req_t    mem_req,
  output dtbe_pkg::blend_ctl_t  ctl
);

  localparam int CW = dtbe_pkg::COORD_W;
  localparam int AW = dtbe_pkg::BANK_AW;
  localparam int WW = dtbe_pkg::WEIGHT_W;
  localparam int FW = dtbe_pkg::WFRAC_W;

  logic                              s1_valid;
  logic                              s1_query;
  logic                              s1_in_range;
  logic [dtbe_pkg::IDX_W-1:0]        s1_idx;
  logic [dtbe_pkg::SAMPLE_W-1:0]     s1_value;
  logic [dtbe_pkg::PROD_W-1:0]       s1_prod;
  logic [dtbe_pkg::POS_W-1:0]        s1_py;
  logic [dtbe_pkg::POS_W-1:0]        s1_px;

  logic                              s2_valid;
  logic                              s2_query;
  logic                              s2_wr;
  logic [dtbe_pkg::IDX_W-1:0]        s2_idx;
  logic [dtbe_pkg::SAMPLE_W-1:0]     s2_value;
  logic [CW-1:0]                     s2_row;
  logic [CW-1:0]                     s2_y;
  logic [CW-1:0]                     s2_x;
  logic [FW-1:0]                     s2_dy;
  logic [FW-1:0]                     s2_dx;

  logic                              s3_valid;
  logic                              s3_query;
  logic                              s3_wr;
  logic [dtbe_pkg::SAMPLE_W-1:0]     s3_value;
  logic [1:0][AW-1:0]                s3_rowbase;
  logic [1:0][CW-1:0]                s3_col;
  logic                              s3_row_odd;
  logic                              s3_col_odd;
  logic [dtbe_pkg::NUM_BANKS-1:0][WW-1:0] s3_weight;

  logic [CW-1:0]                     row_a;
  logic [CW-1:0]                     row_b;
  logic [CW-1:0]                     x_next;
  logic [1:0][CW-1:0]                row_sel;
  logic [1:0][CW-1:0]                col_sel;
  logic [dtbe_pkg::IDX_W-1:0]        load_rem;
  logic [CW-1:0]                     load_col;
  logic [FW:0]                       one_dy;
  logic [FW:0]                       one_dx;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_query    <= item.mode == dtbe_pkg::MODE_QUERY;
    s1_in_range <= 32'(item.sample_index) < 32'(dtbe_pkg::TILE_CELLS);
    s1_idx      <= item.sample_index;
    s1_value    <= item.sample_value;
    s1_prod     <= dtbe_pkg::PROD_W'(item.sample_index) *
                   dtbe_pkg::PROD_W'(dtbe_pkg::RECIP);
    s1_py       <= dtbe_pkg::POS_W'(item.lat_fraction) *
                   dtbe_pkg::POS_W'(dtbe_pkg::TILE_SIDE - 1);
    s1_px       <= dtbe_pkg::POS_W'(item.lon_fraction) *
                   dtbe_pkg::POS_W'(dtbe_pkg::TILE_SIDE - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_query <= s1_query;
    s2_wr    <= !s1_query && s1_in_range;
    s2_idx   <= s1_idx;
    s2_value <= s1_value;
    s2_row   <= s1_prod[dtbe_pkg::RECIP_SHIFT +: CW];
    s2_y     <= s1_py[dtbe_pkg::FRAC_W +: CW];
    s2_x     <= s1_px[dtbe_pkg::FRAC_W +: CW];
    s2_dy    <= s1_py[dtbe_pkg::FRAC_W - FW +: FW];
    s2_dx    <= s1_px[dtbe_pkg::FRAC_W - FW +: FW];
  end

  always_comb begin
    row_a      = CW'(dtbe_pkg::TILE_SIDE - 1) - s2_y;
    row_b      = row_a - CW'(1);
    x_next     = s2_x + CW'(1);
    load_rem   = s2_idx - dtbe_pkg::IDX_W'(dtbe_pkg::IDX_W'(s2_row) *
                                         dtbe_pkg::IDX_W'(dtbe_pkg::TILE_SIDE));
    load_col   = load_rem[CW-1:0];
    row_sel[0] = !s2_query ? s2_row : (row_a[0] ? row_b : row_a);
    row_sel[1] = !s2_query ? s2_row : (row_a[0] ? row_a : row_b);
    col_sel[0] = !s2_query ? load_col : (s2_x[0] ? x_next : s2_x);
    col_sel[1] = !s2_query ? load_col : (s2_x[0] ? s2_x : x_next);
    one_dy     = (FW+1)'(1 << FW) - (FW+1)'(s2_dy);
    one_dx     = (FW+1)'(1 << FW) - (FW+1)'(s2_dx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_query   <= s2_query;
    s3_wr      <= s2_wr;
    s3_value   <= s2_value;
    for (int p = 0; p < 2; p++) begin
      s3_rowbase[p] <= AW'(row_sel[p][CW-1:1]) * AW'(dtbe_pkg::HALF_SIDE);
      s3_col[p]     <= col_sel[p];
    end
    s3_row_odd   <= s2_query ? row_a[0] : s2_row[0];
    s3_col_odd   <= s2_query ? s2_x[0] : load_col[0];
    s3_weight[0] <= WW'(s2_dy) * WW'(one_dx);
    s3_weight[1] <= WW'(s2_dy) * WW'(s2_dx);
    s3_weight[2] <= WW'(one_dy) * WW'(one_dx);
    s3_weight[3] <= WW'(one_dy) * WW'(s2_dx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_req.wr_en <= '0;
      ctl.valid     <= 1'b0;
    end else begin
      for (int b = 0; b < dtbe_pkg::NUM_BANKS; b++) begin
        mem_req.wr_en[b] <= s3_valid && s3_wr &&
                            (dtbe_pkg::bank_of(s3_row_odd, s3_col_odd) == 2'(b));
      end
      ctl.valid <= s3_valid && s3_query;
    end
    for (int b = 0; b < dtbe_pkg::NUM_BANKS; b++) begin
      mem_req.addr[b] <= s3_rowbase[b[1]] + AW'(s3_col[b[0]][CW-1:1]);
    end
    mem_req.wdata <= s3_value;
    ctl.row_odd   <= s3_row_odd;
    ctl.col_odd   <= s3_col_odd;
    ctl.weight    <= s3_weight;
  end

  `DTBE_ASSERT(a_wr_single_bank, $onehot0(mem_req.wr_en), "load beat writes more than one bank")
  `DTBE_ASSERT_IMP(a_wr_excludes_query, |mem_req.wr_en, !ctl.valid, "write and query read overlap")

endmodule

// File: design/dtbe_blend.sv
`include "dem_tile_bilinear_elevation_macros.svh"

module dtbe_blend (
  input  logic                  clk,
  input  logic                  rst,
  input  dtbe_pkg::bank_data_t  rdata,
  input  dtbe_pkg::blend_ctl_t  ctl,
  output logic                  done,
  output dtbe_pkg::result_t     result
);

  localparam int MW = dtbe_pkg::MAC_W;

  dtbe_pkg::blend_ctl_t                ctl_q;
  logic signed [dtbe_pkg::SAMPLE_W-1:0] samp [dtbe_pkg::NUM_BANKS];
  logic                                void_any;

  logic                                b2_valid;
  logic                                b2_void;
  logic signed [MW-1:0]                b2_prod [dtbe_pkg::NUM_BANKS];

  logic                                b3_valid;
  logic                                b3_void;
  logic signed [MW-1:0]                b3_s01;
  logic signed [MW-1:0]                b3_s23;

  logic [MW-1:0]                       total;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q.valid <= 1'b0;
    end else begin
      ctl_q.valid <= ctl.valid;
    end
    ctl_q.row_odd <= ctl.row_odd;
    ctl_q.col_odd <= ctl.col_odd;
    ctl_q.weight  <= ctl.weight;
  end

  always_comb begin
    samp[0]  = rdata[dtbe_pkg::bank_of(!ctl_q.row_odd, ctl_q.col_odd)];
    samp[1]  = rdata[dtbe_pkg::bank_of(!ctl_q.row_odd, !ctl_q.col_odd)];
    samp[2]  = rdata[dtbe_pkg::bank_of(ctl_q.row_odd, ctl_q.col_odd)];
    samp[3]  = rdata[dtbe_pkg::bank_of(ctl_q.row_odd, !ctl_q.col_odd)];
    void_any = 1'b0;
    for (int k = 0; k < dtbe_pkg::NUM_BANKS; k++) begin
      void_any = void_any || (samp[k] == dtbe_pkg::VOID_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b2_valid <= 1'b0;
    end else begin
      b2_valid <= ctl_q.valid;
    end
    b2_void <= void_any;
    for (int k = 0; k < dtbe_pkg::NUM_BANKS; k++) begin
      b2_prod[k] <= MW'(samp[k]) * $signed(MW'(ctl_q.weight[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b3_valid <= 1'b0;
    end else begin
      b3_valid <= b2_valid;
    end
    b3_void <= b2_void;
    b3_s01  <= b2_prod[0] + b2_prod[1];
    b3_s23  <= b2_prod[2] + b2_prod[3];
  end

  assign total = MW'(b3_s01 + b3_s23 + dtbe_pkg::ROUND_BIAS);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= b3_valid;
    end
    result.height_q4  <= b3_void ? '0 : total[dtbe_pkg::FRAC_W +: dtbe_pkg::HEIGHT_W];
    result.void_found <= b3_void;
  end

  `DTBE_ASSERT_IMP(a_blend_depth, done, $past(ctl.valid, 4), "result beat without query read")

endmodule
